### rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Types and constants shared by the stream digest block and its checker, and
// the CRC byte fold and Adler reduction used by the block.
// ----------------------------------------------------------------------------
package cad_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [16:0] ADLER_BASE = 17'd65521;
    localparam logic [15:0] ADLER_A_INIT = 16'd1;
    localparam logic [15:0] ADLER_B_INIT = 16'd0;

    localparam logic FUNC_FOLD  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        logic [31:0] crc_value;
        logic [15:0] adler_low_sum;
        logic [15:0] adler_high_sum;
        logic [31:0] byte_total;
        logic        last_out;
    } digest_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] adler_reduce(input logic [16:0] v);
        logic [16:0] d;
        d = v - ADLER_BASE;
        return (v >= ADLER_BASE) ? d[15:0] : v[15:0];
    endfunction

endpackage

### rtl/crc32_adler32_stream_digest.sv
// ----------------------------------------------------------------------------
// crc32_adler32_stream_digest
// Running reflected CRC-32 and Adler-32 digest over a byte stream, with a
// wrapping byte count, one result word for every input word.
// ----------------------------------------------------------------------------
// A word accepted into the input register moves on into the result register,
// where its digest is shown, once the output is not stalled.
// One word per cycle unless the output stalls; the input and result registers
// form a two-entry pipeline, so a word can be taken while a result waits.
// Reset: rst_n clears both valid flags and returns the digest to its identity
// (CRC all ones, Adler a = 1, b = 0, count 0).
module crc32_adler32_stream_digest
    import cad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    digest_valid,
    input  logic    digest_ready,
    output digest_t digest
);

    logic        stage_valid_reg;
    item_t       stage_reg;
    logic        digest_valid_reg;
    digest_t     digest_reg;

    logic [31:0] crc_reg;
    logic [15:0] sum_a_reg;
    logic [15:0] sum_b_reg;
    logic [31:0] count_reg;

    logic [31:0] crc_next;
    logic [15:0] sum_a_next;
    logic [15:0] sum_b_next;
    logic [31:0] count_next;

    logic        load_result;

    assign load_result  = stage_valid_reg && (!digest_valid_reg || digest_ready);
    assign item_ready   = !stage_valid_reg || load_result;
    assign digest_valid = digest_valid_reg;
    assign digest       = digest_reg;

    always_comb
    begin
        if (stage_reg.func == FUNC_RESET)
        begin
            crc_next   = CRC_INIT;
            sum_a_next = ADLER_A_INIT;
            sum_b_next = ADLER_B_INIT;
            count_next = 32'd0;
        end
        else
        begin
            crc_next   = crc_fold(crc_reg, stage_reg.data_byte);
            sum_a_next = adler_reduce({1'b0, sum_a_reg} + {9'd0, stage_reg.data_byte});
            sum_b_next = adler_reduce({1'b0, sum_b_reg} + {1'b0, sum_a_next});
            count_next = count_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            digest_valid_reg <= 1'b0;
            crc_reg          <= CRC_INIT;
            sum_a_reg        <= ADLER_A_INIT;
            sum_b_reg        <= ADLER_B_INIT;
            count_reg        <= 32'd0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (load_result)
            begin
                digest_valid_reg <= 1'b1;
                crc_reg          <= crc_next;
                sum_a_reg        <= sum_a_next;
                sum_b_reg        <= sum_b_next;
                count_reg        <= count_next;
            end
            else if (digest_ready)
            begin
                digest_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
        if (load_result)
        begin
            digest_reg.crc_value      <= crc_next;
            digest_reg.adler_low_sum  <= sum_a_next;
            digest_reg.adler_high_sum <= sum_b_next;
            digest_reg.byte_total     <= count_next;
            digest_reg.last_out       <= stage_reg.end_of_buffer;
        end
    end

endmodule

### rtl/cad_checker.sv
// ----------------------------------------------------------------------------
// cad_checker
// Port-level checks for the stream digest block, bound to its top level.
// ----------------------------------------------------------------------------
module cad_checker
    import cad_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    digest_valid,
    input logic    digest_ready,
    input digest_t digest
);

    logic [1:0] pending_reg;
    logic       took_item;
    logic       gave_digest;

    assign took_item   = item_valid && item_ready;
    assign gave_digest = digest_valid && digest_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, took_item} - {1'b0, gave_digest};
        end
    end

    // A stalled result word must hold still.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest changed while stalled");

    // Both Adler sums are always reduced below the modulus.
    a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> ({1'b0, digest.adler_low_sum} < ADLER_BASE)
                      && ({1'b0, digest.adler_high_sum} < ADLER_BASE))
        else $error("Adler sum out of range");

    // At most two words are ever held inside the block.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two words held");

    // No result word appears without an accepted input word behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> !digest_valid)
        else $error("digest word without input word");

endmodule

bind crc32_adler32_stream_digest cad_checker u_cad_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-32 and Adler-32 stream digest. A table of
// directed words is followed by buffers of random and constant bytes. Every accepted word
// is run through a local digest predictor, and each result word is compared
// field by field with the oldest pending expectation, under random idling on
// both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb;
    import cad_pkg::*;

    localparam int TOTAL_WORDS = 1820;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        item_t   word;
        bit      typed;
        digest_t want;
    } row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    digest_valid;
    logic    digest_ready = 1'b0;
    digest_t digest;

    logic [31:0] crc_state;
    logic [15:0] sum_a_state;
    logic [15:0] sum_b_state;
    logic [31:0] byte_count_state;

    digest_t pending_digests[$];
    digest_t oldest;
    row_t    rows[$];
    int      words_sent      = 0;
    int      results_seen    = 0;
    int      mismatches      = 0;
    int      cycles          = 0;
    bit      calm            = 1'b0;
    bit      holdoff_pending = 1'b0;

    crc32_adler32_stream_digest u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic digest_t identity_digest(input logic last);
        return digest_t'{crc_value: CRC_INIT, adler_low_sum: ADLER_A_INIT,
                         adler_high_sum: ADLER_B_INIT, byte_total: 32'd0,
                         last_out: last};
    endfunction

    function automatic void clear_digest_state();
        crc_state        = CRC_INIT;
        sum_a_state      = ADLER_A_INIT;
        sum_b_state      = ADLER_B_INIT;
        byte_count_state = 32'd0;
    endfunction

    function automatic digest_t digest_after(input item_t w);
        logic [31:0] r;
        logic [16:0] s;
        if (w.func == FUNC_RESET)
        begin
            clear_digest_state();
        end
        else
        begin
            r = crc_state ^ {24'd0, w.data_byte};
            repeat (8)
            begin
                r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
            end
            crc_state = r;
            s = {1'b0, sum_a_state} + {9'd0, w.data_byte};
            if (s >= ADLER_BASE)
                s = s - ADLER_BASE;
            sum_a_state = s[15:0];
            s = {1'b0, sum_b_state} + {1'b0, sum_a_state};
            if (s >= ADLER_BASE)
                s = s - ADLER_BASE;
            sum_b_state = s[15:0];
            byte_count_state = byte_count_state + 32'd1;
        end
        return digest_t'{crc_value: crc_state, adler_low_sum: sum_a_state,
                         adler_high_sum: sum_b_state, byte_total: byte_count_state,
                         last_out: w.end_of_buffer};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
    endtask

    task automatic check_digest(input digest_t got, input digest_t want);
        if (got.crc_value !== want.crc_value)
            report_mismatch("crc_value", got.crc_value, want.crc_value);
        if (got.adler_low_sum !== want.adler_low_sum)
            report_mismatch("adler_low_sum", 32'(got.adler_low_sum),
                            32'(want.adler_low_sum));
        if (got.adler_high_sum !== want.adler_high_sum)
            report_mismatch("adler_high_sum", 32'(got.adler_high_sum),
                            32'(want.adler_high_sum));
        if (got.byte_total !== want.byte_total)
            report_mismatch("byte_total", got.byte_total, want.byte_total);
        if (got.last_out !== want.last_out)
            report_mismatch("last_out", 32'(got.last_out), 32'(want.last_out));
    endtask

    task automatic add_row(input logic f, input logic [7:0] b, input logic e,
                           input bit typed, input digest_t want);
        row_t r;
        r.word  = item_t'{func: f, data_byte: b, end_of_buffer: e};
        r.typed = typed;
        r.want  = want;
        rows.push_back(r);
    endtask

    task automatic send_word(input item_t w, input bit typed, input digest_t want);
        digest_t predicted;
        calm = (words_sent >= 700) && (words_sent < 1000);
        while (!calm && ($urandom_range(0, 99) < 28))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do @(posedge clk); while (!item_ready);
        predicted = digest_after(w);
        pending_digests.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            if (pending_digests.size() == 0)
            begin
                report_mismatch("result with no word pending", 32'd0, 32'd0);
            end
            else
            begin
                oldest = pending_digests.pop_front();
                check_digest(digest, oldest);
            end
            results_seen++;
        end
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (holdoff_pending)
            begin
                holdoff_pending = 1'b0;
                digest_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                digest_ready <= calm || ($urandom_range(0, 99) >= 28);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int         mode;
        int         len;
        logic [7:0] b;
        logic       f;
        logic       e;
        bit         held;
        bit         paused;

        held   = 1'b0;
        paused = 1'b0;
        clear_digest_state();

        add_row(FUNC_RESET, 8'h00, 1'b1, 1'b1, identity_digest(1'b1));
        add_row(FUNC_RESET, 8'hFF, 1'b0, 1'b1, identity_digest(1'b0));
        add_row(FUNC_FOLD,  8'h00, 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD,  8'hFF, 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD,  8'h80, 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD,  8'h01, 1'b1, 1'b0, '0);
        add_row(FUNC_FOLD,  8'hAA, 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD,  8'h55, 1'b1, 1'b0, '0);
        add_row(FUNC_RESET, 8'hA5, 1'b1, 1'b1, identity_digest(1'b1));
        add_row(FUNC_FOLD,  8'hFF, 1'b1, 1'b0, '0);
        add_row(FUNC_RESET, 8'h5A, 1'b0, 1'b1, identity_digest(1'b0));
        for (int i = 1; i <= 8; i++)
            add_row(FUNC_FOLD, 8'h30 + 8'(i), 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD, 8'h39, 1'b1, 1'b1,
                digest_t'{crc_value: 32'h340B_C6D9, adler_low_sum: 16'h01DE,
                          adler_high_sum: 16'h091E, byte_total: 32'd9,
                          last_out: 1'b1});
        add_row(FUNC_FOLD,  8'hFF, 1'b0, 1'b0, '0);
        add_row(FUNC_FOLD,  8'h00, 1'b1, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed, rows[i].want);

        while (words_sent < TOTAL_WORDS)
        begin
            if (!held && (words_sent >= 400))
            begin
                held            = 1'b1;
                holdoff_pending = 1'b1;
            end
            if (!paused && (words_sent >= 1300))
            begin
                paused = 1'b1;
                item_valid <= 1'b0;
                do @(posedge clk); while (pending_digests.size() != 0);
            end
            mode = $urandom_range(0, 9);
            len  = (mode == 0) ? $urandom_range(260, 400) : $urandom_range(1, 48);
            if ($urandom_range(0, 15) == 0)
                send_word(item_t'{func: FUNC_RESET, data_byte: 8'($urandom),
                                  end_of_buffer: 1'($urandom)}, 1'b0, '0);
            for (int i = 0; (i < len) && (words_sent < TOTAL_WORDS); i++)
            begin
                case (mode)
                    0, 2:    b = 8'hFF;
                    1:       b = 8'h00;
                    3:       b = 8'hF0 | 8'($urandom);
                    default: b = 8'($urandom);
                endcase
                f = FUNC_FOLD;
                e = (i == len - 1);
                if ($urandom_range(0, 39) == 0)
                    f = FUNC_RESET;
                if ($urandom_range(0, 19) == 0)
                    e = ~e;
                send_word(item_t'{func: f, data_byte: b, end_of_buffer: e}, 1'b0, '0);
            end
        end

        item_valid <= 1'b0;
        do @(posedge clk); while (pending_digests.size() != 0);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
